>>> rtl/fba_pkg.sv
// Shared constants, types and control bundles of the frame bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
package fba_pkg;

  // store geometry
  localparam int FRAME_COUNT = 131072;
  localparam int MAP_WORDS   = 4096;
  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = 5;
  localparam int MAP_AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAND_W      = MAP_AW + BIT_W;

  // field widths
  localparam int OPC_W    = 2;
  localparam int FRAME_W  = 20;
  localparam int SHIFT_W  = 5;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 17;

  // width used for range compares against the sizing constants
  localparam int CMP_W = 21;

  // words that can hold an in-range frame
  localparam int SCAN_WORDS_RAW = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int SCAN_WORDS     = (SCAN_WORDS_RAW < MAP_WORDS) ? SCAN_WORDS_RAW : MAP_WORDS;
  localparam logic [MAP_AW-1:0] SCAN_LAST  = MAP_AW'(SCAN_WORDS - 1);
  localparam logic [MAP_AW-1:0] CLEAR_LAST = MAP_AW'(MAP_WORDS - 1);

  // words below FULL_WORDS are wholly in range, the next one holds the tail
  localparam int FULL_WORDS = FRAME_COUNT / WORD_BITS;
  localparam int TAIL_BITS  = FRAME_COUNT % WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK = WORD_BITS'((64'd1 << TAIL_BITS) - 64'd1);

  // word 0 after reset: frame 0 is used
  localparam logic [WORD_BITS-1:0] WORD0_INIT = WORD_BITS'(1);

  typedef enum logic [OPC_W-1:0] {
    OP_QUERY = 2'd0,
    OP_MARK  = 2'd1,
    OP_FREE  = 2'd2,
    OP_ALLOC = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NOMEM = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic finish_single;
    logic scan_next;
    logic finish_scan;
  } fba_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic in_alloc;
    logic found;
    logic scan_last;
  } fba_sts_t;

endpackage
`default_nettype wire

>>> rtl/fba_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/fba_ctrl.sv
// Sequencing state machine of the frame bitmap allocator
`timescale 1ns / 1ps
`default_nettype none
module fba_ctrl import fba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  fba_sts_t sts,
  output fba_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t state, state_next;
  logic   slot_free;
  logic   load;

  // result register can take a new item
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);
  assign load      = cmd.finish_single || cmd.finish_scan;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.in_alloc ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd.finish_single = 1'b1;
          state_next        = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.found || sts.scan_last) begin
          if (slot_free) begin
            cmd.finish_scan = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fba_datapath.sv
// Bitmap store, request registers, word scan logic and result registers
`timescale 1ns / 1ps
`default_nettype none
module fba_datapath import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  fba_cmd_t            cmd,
  output fba_sts_t            sts,
  input  logic [OPC_W-1:0]    opcode,
  input  logic [FRAME_W-1:0]  frame_number,
  input  logic [SHIFT_W-1:0]  align_shift,
  output logic [STATUS_W-1:0] status,
  output logic                is_taken,
  output logic [GRANT_W-1:0]  granted_frame
);

  // request registers
  logic [MAP_AW-1:0]    addr;
  logic [MAP_AW-1:0]    addr_next;
  opcode_t              req_op;
  logic [BIT_W-1:0]     req_bit;
  logic                 req_in_range;
  logic [CAND_W-1:0]    align_mask;

  // store ports
  logic                 ram_we;
  logic [MAP_AW-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] rd_word;

  // incoming request decode
  logic [MAP_AW-1:0]    in_word;
  logic                 in_range;
  logic [CAND_W-1:0]    in_mask;

  // single-frame operation
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] single_wdata;
  logic                 single_we;
  status_t              single_status;
  logic                 single_taken;

  // scan of one word
  logic [WORD_BITS-1:0] aligned_bits;
  logic [WORD_BITS-1:0] valid_bits;
  logic                 word_aligned;
  logic [WORD_BITS-1:0] eligible;
  logic [WORD_BITS-1:0] pick_onehot;
  logic [BIT_W-1:0]     pick_bit;
  logic                 found;
  logic [CAND_W-1:0]    cand;

  assign in_word  = MAP_AW'(frame_number[FRAME_W-1:BIT_W]);
  assign in_range = (CMP_W'(frame_number) < CMP_W'(FRAME_COUNT)) &&
                    (CMP_W'(frame_number[FRAME_W-1:BIT_W]) < CMP_W'(MAP_WORDS));

  // alignment mask: bit i set when i is below align_shift
  always_comb begin
    for (int i = 0; i < CAND_W; i++) begin
      in_mask[i] = (i < 32'(align_shift));
    end
  end

  // read address: request word (word 0 for alloc) on accept, next word on scan, else addr
  always_comb begin
    if (cmd.accept) begin
      ram_raddr = (opcode_t'(opcode) == OP_ALLOC) ? '0 : in_word;
    end else if (cmd.scan_next) begin
      ram_raddr = addr + MAP_AW'(1);
    end else begin
      ram_raddr = addr;
    end
  end

  // address register moves with clearing, accept and scan
  always_comb begin
    addr_next = addr;
    if (cmd.clear_step || cmd.scan_next) begin
      addr_next = addr + MAP_AW'(1);
    end else if (cmd.accept) begin
      addr_next = ram_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      addr <= addr_next;
    end
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op       <= opcode_t'(opcode);
      req_bit      <= frame_number[BIT_W-1:0];
      req_in_range <= in_range;
      align_mask   <= in_mask;
    end
  end

  // query, mark and free on the word just read
  always_comb begin
    bit_sel      = WORD_BITS'(1) << req_bit;
    single_wdata = (req_op == OP_MARK) ? (rd_word | bit_sel) : (rd_word & ~bit_sel);
    single_we    = req_in_range && ((req_op == OP_MARK) || (req_op == OP_FREE));
    single_taken = (req_op == OP_QUERY) && (!req_in_range || rd_word[req_bit]);
    if (req_in_range || (req_op == OP_QUERY)) begin
      single_status = ST_OK;
    end else begin
      single_status = ST_RANGE;
    end
  end

  // free, aligned and in-range bits of the scanned word
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      aligned_bits[b] = ((BIT_W'(b) & align_mask[BIT_W-1:0]) == '0);
    end
    word_aligned = ((addr & align_mask[CAND_W-1:BIT_W]) == '0);
    if (CMP_W'(addr) < CMP_W'(FULL_WORDS)) begin
      valid_bits = '1;
    end else if (CMP_W'(addr) == CMP_W'(FULL_WORDS)) begin
      valid_bits = TAIL_MASK;
    end else begin
      valid_bits = '0;
    end
    eligible    = ~rd_word & aligned_bits & valid_bits & {WORD_BITS{word_aligned}};
    found       = |eligible;
    pick_onehot = eligible & (~eligible + WORD_BITS'(1));
  end

  // lowest eligible bit
  always_comb begin
    pick_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (eligible[b]) begin
        pick_bit = BIT_W'(b);
      end
    end
  end

  assign cand = {addr, pick_bit};

  // store write: clearing pass, single update or granted frame
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = rd_word | pick_onehot;
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_wdata = (addr == '0) ? WORD0_INIT : '0;
    end else if (cmd.finish_single) begin
      ram_we    = single_we;
      ram_wdata = single_wdata;
    end else if (cmd.finish_scan) begin
      ram_we    = found;
    end
  end

  fba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_word)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish_single) begin
      status        <= single_status;
      is_taken      <= single_taken;
      granted_frame <= '0;
    end else if (cmd.finish_scan) begin
      is_taken <= 1'b0;
      if (found) begin
        status        <= ST_OK;
        granted_frame <= GRANT_W'(cand);
      end else begin
        status        <= ST_NOMEM;
        granted_frame <= '0;
      end
    end
  end

  // status toward the controller
  assign sts.clear_last = (addr == CLEAR_LAST);
  assign sts.in_alloc   = (opcode_t'(opcode) == OP_ALLOC);
  assign sts.found      = found;
  assign sts.scan_last  = (addr == SCAN_LAST);

endmodule
`default_nettype wire

>>> rtl/frame_bitmap_allocator.sv
// Query, mark, free and aligned allocation over a frame usage bitmap
// Query, mark and free: result registered in the EXEC state once the result
// register is free; the next item is taken only after that, back in IDLE.
// Allocation: one bitmap word per cycle from word 0, set by the single read port
// of the bitmap memory; result registered at the first word with an eligible frame
// or at the last word SCAN_WORDS - 1; a held result stalls the next item.
// Reset: a clearing pass writes all MAP_WORDS words with frame 0 used; no item is
// accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
module frame_bitmap_allocator import fba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPC_W-1:0]    opcode,
  input  logic [FRAME_W-1:0]  frame_number,
  input  logic [SHIFT_W-1:0]  align_shift,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic                is_taken,
  output logic [GRANT_W-1:0]  granted_frame
);

  fba_cmd_t cmd;
  fba_sts_t sts;

  // sequencer
  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap and datapath
  fba_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .frame_number (frame_number),
    .align_shift  (align_shift),
    .status       (status),
    .is_taken     (is_taken),
    .granted_frame(granted_frame)
  );

`ifndef NO_ASSERTIONS
  // one item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // a failed request never grants a frame
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (granted_frame == '0))
    else $error("frame granted with a failing status");

  // a taken answer only comes with an ok status and no grant
  a_taken_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_taken) |-> ((status == ST_OK) && (granted_frame == '0)))
    else $error("query answer mixed with other result fields");

  // the unused status code never shows
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_NOMEM))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire
